// ----- hdl/sitoa_pkg.sv -----
// Shared types, character constants and the control program for the signed
// integer to ASCII converter. No dependencies; used by the top level.
package sitoa_pkg;

  // Radix register limits and reset value.
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  // Digit to ASCII mapping.
  localparam logic [5:0] DECIMAL_DIGITS  = 6'd10;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;  // '0'
  localparam logic [7:0] CHAR_ALPHA_BASE = 8'h37;  // 'A' - 10
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;  // '-'

  // Program counter of the sequencer.
  localparam int unsigned PROG_LEN = 8;
  typedef logic [2:0] step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,  // wait for an input beat, take magnitude and sign
    OP_SIGN     = 3'd1,  // emit '-' for a negative value
    OP_DIV_INIT = 3'd2,  // clear remainder, arm bit counter
    OP_DIV_STEP = 3'd3,  // one restoring division step
    OP_STORE    = 3'd4,  // store remainder digit, quotient becomes magnitude
    OP_READ     = 3'd5,  // read the next digit, most significant first
    OP_EMIT     = 3'd6,  // send the digit character
    OP_NOP      = 3'd7
  } op_e;

  // Jump condition of a control word; otherwise the step counter advances.
  typedef enum logic [2:0] {
    C_NONE      = 3'd0,
    C_ALWAYS    = 3'd1,
    C_BITS_LEFT = 3'd2,  // division steps remain
    C_QUO_NZ    = 3'd3,  // quotient is not yet zero
    C_MORE      = 3'd4   // more digits to emit
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  // Step addresses used as jump targets.
  localparam step_t STEP_LOAD     = 3'd0;
  localparam step_t STEP_DIV_INIT = 3'd2;
  localparam step_t STEP_DIV_STEP = 3'd3;
  localparam step_t STEP_READ     = 3'd5;

  // Control program, one word per step.
  localparam ctrl_t PROGRAM [PROG_LEN] = '{
    '{op: OP_LOAD,     cond: C_NONE,      target: STEP_LOAD},
    '{op: OP_SIGN,     cond: C_NONE,      target: STEP_LOAD},
    '{op: OP_DIV_INIT, cond: C_NONE,      target: STEP_LOAD},
    '{op: OP_DIV_STEP, cond: C_BITS_LEFT, target: STEP_DIV_STEP},
    '{op: OP_STORE,    cond: C_QUO_NZ,    target: STEP_DIV_INIT},
    '{op: OP_READ,     cond: C_NONE,      target: STEP_LOAD},
    '{op: OP_EMIT,     cond: C_MORE,      target: STEP_READ},
    '{op: OP_NOP,      cond: C_ALWAYS,    target: STEP_LOAD}
  };

endpackage

// ----- hdl/signed_integer_to_ascii_any_base.sv -----
// Signed integer to ASCII text converter in a programmable base, built as a
// microcoded sequencer. Depends on sitoa_pkg for types and the program.
//
// Usage:
//   Input stream s_axis_*: one beat carries one two's complement integer.
//   Output stream m_axis_*: one beat per ASCII character, most significant
//   digit first, preceded by '-' for a negative value; tlast marks the final
//   character of each number. Digits above nine use 'A'..'Z'.
//   cfg_we_i/cfg_wdata_i write the radix (2..36; 0 and 1 act as 2, values
//   above 36 act as 36). Write it only while the block is idle.
// Timing:
//   One input is processed at a time. Each digit is computed on the
//   bit-serial restoring divider (init, VALUE_BITS steps, store), and
//   each character takes a digit store read and a send. A minus sign is
//   sent right after the input beat; the first digit appears after all
//   digits are computed.
// Reset and stall:
//   Reset returns the step counter to the input wait step, empties the
//   output register and sets the radix to ten. A stalled receiver holds the
//   output beat; the sequencer waits at its sign or emit step. The next input
//   beat is taken while the final character of the previous number is still
//   pending.
module signed_integer_to_ascii_any_base #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [5:0]                            cfg_wdata_i,    // radix
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // value
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [7:0]                            m_axis_tdata,   // character
  output logic                                  m_axis_tlast    // last
);

  localparam int unsigned IDX_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned BIT_W = $clog2(VALUE_BITS);

  // Sequencer state.
  sitoa_pkg::step_t step_q, step_d;
  sitoa_pkg::ctrl_t ctrl;
  logic             hold;
  logic             cond_true;

  // Datapath registers.
  logic [5:0]            radix_q;
  logic [5:0]            radix_eff;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [5:0]            rem_q, rem_d;
  logic [BIT_W-1:0]      bitcnt_q, bitcnt_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cnt_dec;
  logic [VALUE_BITS-1:0] in_value;

  // Division step signals.
  logic [6:0] trial;
  logic [6:0] diff;
  logic       ge;

  // Digit store.
  logic [5:0] digit_mem [VALUE_BITS];
  logic [5:0] rdata_q;
  logic       mem_we;
  logic       mem_re;

  // Output register.
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q, m_data_d;
  logic       m_last_q, m_last_d;
  logic       out_free;
  logic       emit;

  // Clamp the radix into the supported range.
  always_comb begin
    radix_eff = radix_q;
    if (radix_q < sitoa_pkg::RADIX_MIN) begin
      radix_eff = sitoa_pkg::RADIX_MIN;
    end else if (radix_q > sitoa_pkg::RADIX_MAX) begin
      radix_eff = sitoa_pkg::RADIX_MAX;
    end
  end

  // Radix register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= sitoa_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign in_value = s_axis_tdata[VALUE_BITS-1:0];
  assign out_free = !m_valid_q || m_axis_tready;
  assign cnt_dec  = cnt_q - CNT_W'(1);

  // Fetch the control word and decide whether the step must wait.
  always_comb begin
    ctrl = sitoa_pkg::PROGRAM[step_q];
    case (ctrl.op)
      sitoa_pkg::OP_LOAD: hold = !s_axis_tvalid;
      sitoa_pkg::OP_SIGN: hold = neg_q && !out_free;
      sitoa_pkg::OP_EMIT: hold = !out_free;
      default:            hold = 1'b0;
    endcase
  end

  // Jump condition and next step.
  always_comb begin
    case (ctrl.cond)
      sitoa_pkg::C_ALWAYS:    cond_true = 1'b1;
      sitoa_pkg::C_BITS_LEFT: cond_true = (bitcnt_q != '0);
      sitoa_pkg::C_QUO_NZ:    cond_true = (quo_q != '0);
      sitoa_pkg::C_MORE:      cond_true = (cnt_q != CNT_W'(1));
      default:                cond_true = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (cond_true) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + 3'd1;
    end
  end

  // One restoring division step on the magnitude held in quo_q.
  always_comb begin
    trial = {rem_q, quo_q[VALUE_BITS-1]};
    diff  = trial - {1'b0, radix_eff};
    ge    = (trial >= {1'b0, radix_eff});
  end

  // Datapath control from the current control word.
  always_comb begin
    neg_d    = neg_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    bitcnt_d = bitcnt_q;
    cnt_d    = cnt_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    emit     = 1'b0;
    m_data_d = m_data_q;
    m_last_d = m_last_q;
    if (!hold) begin
      case (ctrl.op)
        sitoa_pkg::OP_LOAD: begin
          neg_d = in_value[VALUE_BITS-1];
          quo_d = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          cnt_d = '0;
        end
        sitoa_pkg::OP_SIGN: begin
          if (neg_q) begin
            emit     = 1'b1;
            m_data_d = sitoa_pkg::CHAR_MINUS;
            m_last_d = 1'b0;
          end
        end
        sitoa_pkg::OP_DIV_INIT: begin
          rem_d    = '0;
          bitcnt_d = BIT_W'(VALUE_BITS - 1);
        end
        sitoa_pkg::OP_DIV_STEP: begin
          rem_d    = ge ? diff[5:0] : trial[5:0];
          quo_d    = {quo_q[VALUE_BITS-2:0], ge};
          bitcnt_d = bitcnt_q - BIT_W'(1);
        end
        sitoa_pkg::OP_STORE: begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        sitoa_pkg::OP_READ: begin
          mem_re = 1'b1;
        end
        sitoa_pkg::OP_EMIT: begin
          emit     = 1'b1;
          m_data_d = (rdata_q < sitoa_pkg::DECIMAL_DIGITS)
                   ? (sitoa_pkg::CHAR_ZERO + {2'b00, rdata_q})
                   : (sitoa_pkg::CHAR_ALPHA_BASE + {2'b00, rdata_q});
          m_last_d = (cnt_q == CNT_W'(1));
          cnt_d    = cnt_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // Output beat valid flag.
  always_comb begin
    if (emit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= sitoa_pkg::STEP_LOAD;
      bitcnt_q  <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      quo_q     <= '0;
    end else begin
      step_q    <= step_d;
      bitcnt_q  <= bitcnt_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      quo_q     <= quo_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  // Digit store, least significant digit at index zero, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= rem_q;
    end
    if (mem_re) begin
      rdata_q <= digit_mem[cnt_dec[IDX_W-1:0]];
    end
  end

  assign s_axis_tready = (ctrl.op == sitoa_pkg::OP_LOAD);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- hdl/sitoa_checker.sv -----
// Port-level checks for the signed integer to ASCII converter, bound to the
// top level. Depends only on the top level's ports.
module sitoa_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [7:0]                            m_axis_tdata,
  input logic                                  m_axis_tlast
);

  // An accepted number keeps the input closed while it is converted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  // An offered input beat waits unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting input beat changed");

  // Every character is a sign, a decimal digit or an upper-case letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == 8'h2D)
      || (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39)
      || (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A))
    else $error("character outside the digit alphabet");

  // A minus sign is always followed by digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == 8'h2D) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

  // A stalled output beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind signed_integer_to_ascii_any_base sitoa_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_sitoa_checker (.*);
